// File: rtl/sktu_pkg.sv
// Shared types and codes for the sorted key table unit.
package sktu_pkg;

  localparam int KEY_W = 32;
  localparam int CMD_W = 2;
  localparam int STATUS_W = 2;
  localparam int POS_W = 4;
  localparam int COUNT_W = 5;
  localparam int CAPACITY_DEFAULT = 16;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd2;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic cmp;  // capture compare flags against the command key
    logic ins;  // open a slot at the boundary and shift right
    logic del;  // close the slot at the boundary and shift left
  } sktu_cell_ctl_t;

endpackage

// File: rtl/sktu_cell.sv
// One slot of the sorted key chain: holds a key and its compare flags.
module sktu_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  sktu_pkg::sktu_cell_ctl_t     ctl,
  input  logic                         valid,
  input  logic signed [sktu_pkg::KEY_W-1:0] new_key,
  input  logic signed [sktu_pkg::KEY_W-1:0] left_key,
  input  logic signed [sktu_pkg::KEY_W-1:0] right_key,
  input  logic                         left_lt,
  output logic signed [sktu_pkg::KEY_W-1:0] key,
  output logic                         lt,
  output logic                         eq,
  output logic                         bnd
);
  import sktu_pkg::*;

  // First slot not below the command key.
  assign bnd = left_lt & ~lt;

  always_ff @(posedge clk) begin
    if (rst) begin
      lt <= 1'b0;
      eq <= 1'b0;
    end else if (ctl.cmp) begin
      lt <= valid && (key < new_key);
      eq <= valid && (key == new_key);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins && !lt) begin
      key <= bnd ? new_key : left_key;
    end else if (ctl.del && !lt) begin
      key <= right_key;
    end
  end

endmodule

// File: rtl/sorted_key_table_unit.sv
// Top level of the sorted key table unit: command port, cell chain and result register.
//
// Keeps up to CAPACITY signed keys in ascending order in a chain of cells.
// Command channel (s_axis_*): one word per command, tuser carries the
// operation (insert, delete, search, clear) and tdata the signed key.
// Result channel (m_axis_*): one word per command with status, position and
// the entry count after the command.
// Each command passes through the accept edge, a compare edge at which
// every cell registers key < new and key == new in parallel, and an update
// edge at which the cells shift left or right around the boundary slot and
// the result register loads. A new command is taken only after the update
// step of the last one, set by the compare/update sequence through the
// shared chain; s_axis_tready is high whenever the sequencer is idle,
// even while a result still waits on the result port.
// If the receiver stalls, the sequencer holds in its update step until the
// result register frees, so nothing is lost or repeated.
// Reset empties the table (count to zero) and drops any pending result;
// stored keys are not cleared, since slots at or above the count are never
// read.
module sorted_key_table_unit #(
  parameter int CAPACITY = sktu_pkg::CAPACITY_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] key
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [1:0] status, [5:2] position,
                                      // [10:6] entry_count, [15:11] zero
);
  import sktu_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]              state;
  logic [1:0]              state_next;
  logic [CMD_W-1:0]        cmd_r;
  logic signed [KEY_W-1:0] key_r;
  logic [CW-1:0]           count;
  logic [CW-1:0]           count_next;

  logic                    out_valid;
  logic [STATUS_W-1:0]     out_status;
  logic [POS_W-1:0]        out_pos;
  logic [COUNT_W-1:0]      out_count;

  sktu_cell_ctl_t          ctl;
  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0]     cell_lt;
  logic [CAPACITY-1:0]     cell_eq;
  logic [CAPACITY-1:0]     cell_bnd;
  logic [CAPACITY-1:0]     cell_valid;

  logic                    in_fire;
  logic                    upd_go;
  logic                    full;
  logic                    found;
  logic [IW-1:0]           bnd_pos;
  logic [STATUS_W-1:0]     status_next;
  logic [IW-1:0]           pos_next;
  logic [IW+POS_W-1:0]     pos_wide;
  logic [CW+COUNT_W-1:0]   count_wide;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  // Update only once the result register can take the new word.
  assign upd_go        = (state == ST_UPD) && (!out_valid || m_axis_tready);
  assign full          = (count == CW'(CAPACITY));

  // Cell chain: each cell sees its neighbours' keys and the left compare flag.
  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      assign cell_valid[g] = (count > CW'(g));
      sktu_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .valid     (cell_valid[g]),
        .new_key   (key_r),
        .left_key  ((g == 0) ? key_r : cell_key[(g == 0) ? 0 : g-1]),
        .right_key ((g == CAPACITY-1) ? cell_key[g] : cell_key[(g == CAPACITY-1) ? g : g+1]),
        .left_lt   ((g == 0) ? 1'b1 : cell_lt[(g == 0) ? 0 : g-1]),
        .key       (cell_key[g]),
        .lt        (cell_lt[g]),
        .eq        (cell_eq[g]),
        .bnd       (cell_bnd[g])
      );
    end
  endgenerate

  // Boundary index and hit: there is at most one boundary slot, so OR the slot numbers.
  always_comb begin
    bnd_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      bnd_pos = bnd_pos | (cell_bnd[i] ? IW'(i) : '0);
    end
    found = |(cell_bnd & cell_eq);
  end

  // Decide the outcome and drive the chain.
  always_comb begin
    ctl         = '0;
    ctl.cmp     = (state == ST_CMP);
    status_next = STATUS_DONE;
    pos_next    = '0;
    count_next  = count;
    case (cmd_r)
      CMD_INSERT: begin
        if (full) begin
          status_next = STATUS_FULL;
        end else begin
          pos_next   = bnd_pos;
          count_next = count + CW'(1);
          ctl.ins    = upd_go;
        end
      end
      CMD_DELETE: begin
        if (found) begin
          pos_next   = bnd_pos;
          count_next = count - CW'(1);
          ctl.del    = upd_go;
        end else begin
          status_next = STATUS_MISSING;
        end
      end
      CMD_SEARCH: begin
        if (found) begin
          pos_next = bnd_pos;
        end else begin
          status_next = STATUS_MISSING;
        end
      end
      CMD_CLEAR: begin
        count_next = '0;
      end
      default: begin
        status_next = STATUS_DONE;
      end
    endcase
  end

  // Report position and count modulo the field widths.
  assign pos_wide   = {{POS_W{1'b0}}, pos_next};
  assign count_wide = {{COUNT_W{1'b0}}, count_next};

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (upd_go) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (upd_go) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the command word for the compare and update steps.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= s_axis_tuser;
      key_r <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_status <= status_next;
      out_pos    <= pos_wide[POS_W-1:0];
      out_count  <= count_wide[COUNT_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_count, out_pos, out_status};

  // The table never holds more keys than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  // The compare flags form a thermometer, so at most one boundary slot.
  a_one_boundary: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) |-> $onehot0(cell_bnd))
    else $error("more than one boundary slot");

  // An accepted command always goes to the compare step next.
  a_accept_to_cmp: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == ST_CMP))
    else $error("accepted command skipped the compare step");

  // A fresh result only appears after an update step.
  a_result_after_upd: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_UPD))
    else $error("result without an update step");

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the sorted key table unit: directed table, then random commands.
`timescale 1ns / 100ps

module testbench;
  import sktu_pkg::*;

  localparam int CAPACITY = CAPACITY_DEFAULT;
  localparam int RANDOM_WORDS = 1750;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int REPORT_LIMIT = 10;

  // One result word as the block reports it.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  entry_count;
  } table_result_t;

  // One row of the directed table; a row with reps > 1 steps the key by one each time.
  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    int               reps;
    bit               typed;
    table_result_t    want;
  } opening_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // [31:0] key
  logic [1:0] s_axis_tuser = '0;   // [1:0] cmd
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // [1:0] status, [5:2] position, [10:6] entry_count

  // Shadow copy of the table, kept in ascending signed order.
  logic signed [KEY_W-1:0] shadow_keys [0:CAPACITY-1];
  int shadow_count = 0;

  table_result_t pending_results [$];
  int mismatches = 0;
  int cycle_count = 0;
  int words_sent = 0;
  bit calm = 1'b0;        // no idling on either side while set
  bit hold_done = 1'b0;

  opening_row_t opening_rows [0:23];

  sorted_key_table_unit #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if the block stops making progress.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // First slot holding a key at or above the given one, or the count if none.
  function automatic int first_at_or_above(input logic signed [KEY_W-1:0] key);
    int slot;
    slot = 0;
    while (slot < shadow_count && shadow_keys[slot] < key)
      slot++;
    return slot;
  endfunction

  // Apply one command to the shadow table and return the result it should give.
  function automatic table_result_t table_apply(input logic [CMD_W-1:0] cmd,
                                                input logic signed [KEY_W-1:0] key);
    table_result_t r;
    int slot;
    r = '0;
    r.status = STATUS_DONE;
    case (cmd)
      CMD_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else begin
          slot = first_at_or_above(key);
          // open the slot: everything from the boundary up moves right
          for (int i = shadow_count; i > slot; i--)
            shadow_keys[i] = shadow_keys[i-1];
          shadow_keys[slot] = key;
          shadow_count++;
          r.position = slot[POS_W-1:0];
        end
      end
      CMD_DELETE, CMD_SEARCH: begin
        slot = first_at_or_above(key);
        if (slot < shadow_count && shadow_keys[slot] == key) begin
          r.position = slot[POS_W-1:0];
          if (cmd == CMD_DELETE) begin
            // close the gap: everything above moves left
            for (int i = slot; i + 1 < shadow_count; i++)
              shadow_keys[i] = shadow_keys[i+1];
            shadow_count--;
          end
        end else begin
          r.status = STATUS_MISSING;
        end
      end
      default: shadow_count = 0;
    endcase
    r.entry_count = shadow_count[COUNT_W-1:0];
    return r;
  endfunction

  // Key mix: many small keys for duplicates, stored keys for hits, extremes, and full range.
  function automatic logic [KEY_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35)
      return int'($urandom_range(0, 8)) - 4;
    if (roll < 60 && shadow_count > 0)
      return shadow_keys[$urandom_range(0, shadow_count - 1)];
    if (roll < 70) begin
      case ($urandom_range(0, 5))
        0: return 32'h8000_0000;
        1: return 32'h8000_0001;
        2: return 32'h7FFF_FFFF;
        3: return 32'h7FFF_FFFE;
        4: return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom();
  endfunction

  // Pick a command; the insert share moves between phases so the fill level wanders.
  function automatic logic [CMD_W-1:0] pick_cmd(input int n);
    int roll;
    int insert_share;
    roll = $urandom_range(0, 99);
    case ((n / 250) % 4)
      0: insert_share = 45;
      1: insert_share = 60;
      2: insert_share = 25;
      default: insert_share = 38;
    endcase
    if (roll < 3)
      return CMD_CLEAR;
    if (roll < 3 + insert_share)
      return CMD_INSERT;
    if (roll < 3 + insert_share + (97 - insert_share) / 2)
      return CMD_DELETE;
    return CMD_SEARCH;
  endfunction

  // Offer one word from a falling edge; return at the falling edge after it is taken.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                           input bit typed, input table_result_t want);
    table_result_t predicted;
    while (!calm && $urandom_range(0, 99) < 32) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= key;
    @(posedge clk);
    while (!s_axis_tready)
      @(posedge clk);
    // accepted at this edge: advance the shadow table either way
    predicted = table_apply(cmd, key);
    pending_results.push_back(typed ? want : predicted);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic note_mismatch(input string what, input table_result_t want,
                               input table_result_t seen);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("mismatch at %0t: %s: expected st=%0d pos=%0d cnt=%0d, got st=%0d pos=%0d cnt=%0d",
               $realtime, what, want.status, want.position, want.entry_count,
               seen.status, seen.position, seen.entry_count);
  endtask

  // Result checker: take each word at the edge it is accepted.
  always @(posedge clk) begin
    table_result_t seen;
    table_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen.status = m_axis_tdata[1:0];
      seen.position = m_axis_tdata[5:2];
      seen.entry_count = m_axis_tdata[10:6];
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing outstanding", '0, seen);
      end else begin
        want = pending_results.pop_front();
        if (seen.status != want.status)
          note_mismatch("status", want, seen);
        else if (seen.position != want.position)
          note_mismatch("position", want, seen);
        else if (seen.entry_count != want.entry_count)
          note_mismatch("entry count", want, seen);
      end
    end
  end

  // Receiver: random stalls, one long hold-off to back the block up, no stalls while calm.
  initial begin
    forever begin
      @(negedge clk);
      if (!hold_done && words_sent >= 600) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 32);
      end
    end
  end

  initial begin
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;

    // Directed table: typed expectations where they are obvious, shadow table elsewhere.
    opening_rows = '{
      // empty table: lookups miss
      '{CMD_SEARCH, 32'h0000_0000, 1, 1'b1, '{STATUS_MISSING, 4'd0, 5'd0}},
      '{CMD_DELETE, 32'h0000_0005, 1, 1'b1, '{STATUS_MISSING, 4'd0, 5'd0}},
      // extremes and duplicates
      '{CMD_INSERT, 32'h7FFF_FFFF, 1, 1'b1, '{STATUS_DONE, 4'd0, 5'd1}},
      '{CMD_INSERT, 32'h8000_0000, 1, 1'b1, '{STATUS_DONE, 4'd0, 5'd2}},
      '{CMD_INSERT, 32'h0000_0000, 1, 1'b1, '{STATUS_DONE, 4'd1, 5'd3}},
      '{CMD_INSERT, 32'h0000_0000, 1, 1'b1, '{STATUS_DONE, 4'd1, 5'd4}},
      '{CMD_INSERT, 32'hFFFF_FFFF, 1, 1'b1, '{STATUS_DONE, 4'd1, 5'd5}},
      // search hits the lowest equal entry
      '{CMD_SEARCH, 32'h0000_0000, 1, 1'b1, '{STATUS_DONE, 4'd2, 5'd5}},
      '{CMD_SEARCH, 32'h7FFF_FFFF, 1, 1'b1, '{STATUS_DONE, 4'd4, 5'd5}},
      '{CMD_SEARCH, 32'h8000_0000, 1, 1'b1, '{STATUS_DONE, 4'd0, 5'd5}},
      '{CMD_DELETE, 32'h0000_0000, 1, 1'b1, '{STATUS_DONE, 4'd2, 5'd4}},
      '{CMD_SEARCH, 32'h0000_0001, 1, 1'b1, '{STATUS_MISSING, 4'd0, 5'd4}},
      // fill to capacity, then refuse
      '{CMD_INSERT, 32'h0000_0064, 12, 1'b0, '0},
      '{CMD_INSERT, 32'h0000_0005, 1, 1'b1, '{STATUS_FULL, 4'd0, 5'd16}},
      '{CMD_SEARCH, 32'h7FFF_FFFF, 1, 1'b1, '{STATUS_DONE, 4'd15, 5'd16}},
      '{CMD_DELETE, 32'h7FFF_FFFF, 1, 1'b1, '{STATUS_DONE, 4'd15, 5'd15}},
      '{CMD_DELETE, 32'h8000_0000, 1, 1'b1, '{STATUS_DONE, 4'd0, 5'd14}},
      '{CMD_INSERT, 32'h8000_0000, 1, 1'b0, '0},
      '{CMD_INSERT, 32'hAAAA_5555, 1, 1'b0, '0},
      '{CMD_INSERT, 32'h5555_AAAA, 1, 1'b1, '{STATUS_FULL, 4'd0, 5'd16}},
      // clear empties the table
      '{CMD_CLEAR, 32'hFFFF_FFFF, 1, 1'b1, '{STATUS_DONE, 4'd0, 5'd0}},
      '{CMD_SEARCH, 32'h0000_0000, 1, 1'b1, '{STATUS_MISSING, 4'd0, 5'd0}},
      '{CMD_DELETE, 32'h8000_0000, 1, 1'b1, '{STATUS_MISSING, 4'd0, 5'd0}},
      '{CMD_INSERT, 32'h1234_5678, 1, 1'b1, '{STATUS_DONE, 4'd0, 5'd1}}
    };

    // hold reset, then release it on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    shadow_count = 0;
    @(negedge clk);

    foreach (opening_rows[r]) begin
      for (int k = 0; k < opening_rows[r].reps; k++)
        send_word(opening_rows[r].cmd, opening_rows[r].key + k,
                  opening_rows[r].typed, opening_rows[r].want);
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      calm = (n >= 800 && n < 1100);
      cmd = pick_cmd(n);
      key = pick_key();
      send_word(cmd, key, 1'b0, '0);
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    // drain, then give any stray word time to show up
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
